// ----- rtl/ldsc_pkg.sv -----
// Shared constants, status codes and divider control type for the solution counter.
package ldsc_pkg;

    // Default coefficient width, divider numerator width and fixed result widths.
    localparam int DEF_WIDTH = 32;
    localparam int NUM_W     = 64;
    localparam int GCD_W     = 32;
    localparam int PART_W    = 64;
    localparam int COUNT_W   = 33;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NODIV = 2'd1,
        ST_ZERO  = 2'd2
    } status_t;

    // Control group from the sequencer to the shared divider.
    typedef struct packed {
        logic start;
        logic short_op;
    } div_ctl_t;

endpackage

// ----- rtl/ldsc_div.sv -----
// Shared iterative restoring divider, one quotient bit per cycle.
module ldsc_div #(
    parameter int NW = ldsc_pkg::NUM_W,
    parameter int DW = ldsc_pkg::DEF_WIDTH,
    parameter int SW = ldsc_pkg::DEF_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ldsc_pkg::div_ctl_t   ctl,
    input  logic [NW-1:0]        num,
    input  logic [DW-1:0]        den,
    output logic                 done,
    output logic [NW-1:0]        quot,
    output logic [DW-1:0]        rem
);

    localparam int CNT_W = $clog2(NW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DW-1:0]     den_reg;
    logic [DW-1:0]     rem_reg;
    logic [NW-1:0]     quo_reg;
    logic [DW:0]       trial;
    logic [DW:0]       diff;
    logic              fits;

    // One restoring step: bring down the next numerator bit and try the subtract.
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.short_op ? CNT_W'(SW) : CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register; a short operand is left aligned.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            quo_reg <= ctl.short_op ? (num << (NW - SW)) : num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/ldsc_mul.sv -----
// Shared signed multiplier with a registered product.
module ldsc_mul #(
    parameter int OPW = ldsc_pkg::DEF_WIDTH + 1
) (
    input  logic                      clk,
    input  logic signed [OPW-1:0]     op_a,
    input  logic signed [OPW-1:0]     op_b,
    output logic signed [2*OPW-1:0]   prod
);

    logic signed [2*OPW-1:0] prod_reg;

    // Product is registered before any use.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/linear_diophantine_solution_counter.sv -----
// Top level: sequencer for gcd, particular solution and box count of a*x + b*y = c.
//
// Usage: an input beat carries coef_a, coef_b, rhs_c and the box bounds x_low..x_high,
// y_low..y_high on a valid/ready channel. One result beat per input comes out on a
// valid/ready channel: status, gcd_value, part_x, part_y and box_count.
// The block takes one item at a time; in_ready is high only while the sequencer idles.
// Timing is set by one shared restoring divider (one quotient bit per cycle) and one
// shared registered multiplier. Each Euclid step uses one division and two
// multiplies; the gcd checks and scaling use three divisions and two multiplies,
// and the four box bound divisions follow. The next input beat is taken once the
// result is loaded and the sequencer is back in idle; an item needs at most about
// 46 Euclid steps for WIDTH 32.
// A zero coefficient or a c that is not a multiple of the gcd ends early.
// The finished result sits in an output register, so a new item is accepted while
// the receiver stalls; only a second finished result waits for the register to free.
// Reset clears the sequencer, the bound index and the output valid flag.
module linear_diophantine_solution_counter #(
    parameter int WIDTH = ldsc_pkg::DEF_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [WIDTH-1:0]               coef_a,
    input  logic signed [WIDTH-1:0]               coef_b,
    input  logic signed [WIDTH-1:0]               rhs_c,
    input  logic signed [WIDTH-1:0]               x_low,
    input  logic signed [WIDTH-1:0]               x_high,
    input  logic signed [WIDTH-1:0]               y_low,
    input  logic signed [WIDTH-1:0]               y_high,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            status,
    output logic [ldsc_pkg::GCD_W-1:0]            gcd_value,
    output logic signed [ldsc_pkg::PART_W-1:0]    part_x,
    output logic signed [ldsc_pkg::PART_W-1:0]    part_y,
    output logic [ldsc_pkg::COUNT_W-1:0]          box_count
);

    localparam int MW = WIDTH;
    localparam int CW = WIDTH + 1;
    localparam int NW = ldsc_pkg::NUM_W;

    typedef enum logic [15:0] {
        S_IDLE    = 16'b0000_0000_0000_0001,
        S_EU_CHK  = 16'b0000_0000_0000_0010,
        S_EU_DIV  = 16'b0000_0000_0000_0100,
        S_EU_MX   = 16'b0000_0000_0000_1000,
        S_EU_MY   = 16'b0000_0000_0001_0000,
        S_EU_UPD  = 16'b0000_0000_0010_0000,
        S_CG_DIV  = 16'b0000_0000_0100_0000,
        S_AP_DIV  = 16'b0000_0000_1000_0000,
        S_BP_DIV  = 16'b0000_0001_0000_0000,
        S_X0      = 16'b0000_0010_0000_0000,
        S_Y0      = 16'b0000_0100_0000_0000,
        S_Y0_END  = 16'b0000_1000_0000_0000,
        S_K_START = 16'b0001_0000_0000_0000,
        S_K_DIV   = 16'b0010_0000_0000_0000,
        S_CNT     = 16'b0100_0000_0000_0000,
        S_FIN     = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic signed [WIDTH-1:0] a_reg, b_reg, c_reg;
    logic signed [WIDTH-1:0] xl_reg, xh_reg, yl_reg, yh_reg;
    logic [MW-1:0]           p_reg, q_reg, t_reg, r_reg;
    logic signed [CW-1:0]    xp_reg, yp_reg, xq_reg, yq_reg, nx_reg;
    logic signed [CW-1:0]    m_reg, ap_reg, bp_reg;
    logic signed [NW-1:0]    x0_reg, y0_reg, kl_reg, kh_reg;
    logic [ldsc_pkg::COUNT_W-1:0] cnt_reg;
    ldsc_pkg::status_t       stat_reg;
    logic [1:0]              kidx_reg;

    logic                    out_valid_reg;
    ldsc_pkg::status_t       status_out_reg;
    logic [ldsc_pkg::GCD_W-1:0]          gcd_out_reg;
    logic signed [ldsc_pkg::PART_W-1:0]  px_out_reg, py_out_reg;
    logic [ldsc_pkg::COUNT_W-1:0]        count_out_reg;

    ldsc_pkg::div_ctl_t      div_ctl;
    logic [NW-1:0]           div_num;
    logic [MW-1:0]           div_den;
    logic                    div_done;
    logic [NW-1:0]           div_quot;
    logic [MW-1:0]           div_rem;

    logic signed [CW-1:0]    mul_a, mul_b;
    logic signed [2*CW-1:0]  mul_prod;
    logic signed [NW-1:0]    prod64;

    logic                    zero_coef;
    logic                    out_free;
    logic signed [CW-1:0]    quot_s;
    logic signed [NW-1:0]    k_n;
    logic [NW-1:0]           k_abs;
    logic                    k_neg;
    logic                    k_ceil;
    logic [MW-1:0]           k_d;
    logic                    k_adj;
    logic [NW-1:0]           k_q;
    logic signed [NW-1:0]    k_val;
    logic signed [NW-1:0]    k_span;

    // Magnitude of an input field.
    function automatic logic [MW-1:0] mag_in(input logic signed [WIDTH-1:0] v);
        logic signed [CW-1:0] e;
        e = CW'(v);
        return MW'(v[WIDTH-1] ? -e : e);
    endfunction

    // Magnitude of a reduced coefficient.
    function automatic logic [MW-1:0] mag_cw(input logic signed [CW-1:0] v);
        return MW'(v[CW-1] ? -v : v);
    endfunction

    assign zero_coef = (a_reg == '0) || (b_reg == '0);
    assign out_free  = !out_valid_reg || out_ready;
    assign quot_s    = signed'({1'b0, div_quot[MW-1:0]});
    assign prod64    = NW'(mul_prod);

    ldsc_div #(
        .NW (NW),
        .DW (MW),
        .SW (MW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    ldsc_mul #(
        .OPW (CW)
    ) u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    // Box bound numerator and divisor for the current bound index.
    always_comb
    begin
        unique case (kidx_reg)
            2'd0:
            begin
                k_n    = bp_reg[CW-1] ? (x0_reg - NW'(xh_reg)) : (NW'(xl_reg) - x0_reg);
                k_ceil = 1'b1;
                k_d    = mag_cw(bp_reg);
            end
            2'd1:
            begin
                k_n    = bp_reg[CW-1] ? (x0_reg - NW'(xl_reg)) : (NW'(xh_reg) - x0_reg);
                k_ceil = 1'b0;
                k_d    = mag_cw(bp_reg);
            end
            2'd2:
            begin
                k_n    = ap_reg[CW-1] ? (NW'(yl_reg) - y0_reg) : (y0_reg - NW'(yh_reg));
                k_ceil = 1'b1;
                k_d    = mag_cw(ap_reg);
            end
            default:
            begin
                k_n    = ap_reg[CW-1] ? (NW'(yh_reg) - y0_reg) : (y0_reg - NW'(yl_reg));
                k_ceil = 1'b0;
                k_d    = mag_cw(ap_reg);
            end
        endcase
    end

    // Floor or ceiling of the signed quotient from the magnitude division.
    assign k_neg  = k_n[NW-1];
    assign k_abs  = k_neg ? NW'(-k_n) : NW'(k_n);
    assign k_adj  = (div_rem != '0) && (k_neg != k_ceil);
    assign k_q    = div_quot + NW'(k_adj);
    assign k_val  = k_neg ? -signed'(k_q) : signed'(k_q);
    assign k_span = kh_reg - kl_reg;

    // Divider operand selection and start.
    always_comb
    begin
        div_ctl.start    = 1'b0;
        div_ctl.short_op = 1'b1;
        div_num          = NW'(q_reg);
        div_den          = q_reg;
        unique case (state_reg)
            S_EU_CHK:
            begin
                if (p_reg != '0)
                begin
                    div_ctl.start = 1'b1;
                    div_den       = p_reg;
                end
                else
                begin
                    div_ctl.start = !zero_coef;
                    div_num       = NW'(mag_in(c_reg));
                end
            end
            S_CG_DIV:
            begin
                div_ctl.start = div_done && (div_rem == '0);
                div_num       = NW'(mag_in(a_reg));
            end
            S_AP_DIV:
            begin
                div_ctl.start = div_done;
                div_num       = NW'(mag_in(b_reg));
            end
            S_K_START:
            begin
                div_ctl.start    = 1'b1;
                div_ctl.short_op = 1'b0;
                div_num          = k_abs;
                div_den          = k_d;
            end
            default:
            begin
                div_ctl.start = 1'b0;
            end
        endcase
    end

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = signed'({1'b0, t_reg});
        mul_b = xp_reg;
        unique case (state_reg)
            S_EU_MY:
            begin
                mul_b = yp_reg;
            end
            S_X0:
            begin
                mul_a = xq_reg;
                mul_b = m_reg;
            end
            S_Y0:
            begin
                mul_a = yq_reg;
                mul_b = m_reg;
            end
            default:
            begin
                mul_b = xp_reg;
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EU_CHK;
                end
            end
            S_EU_CHK:
            begin
                if (p_reg != '0)
                begin
                    state_next = S_EU_DIV;
                end
                else if (zero_coef)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_CG_DIV;
                end
            end
            S_EU_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_EU_MX;
                end
            end
            S_EU_MX:  state_next = S_EU_MY;
            S_EU_MY:  state_next = S_EU_UPD;
            S_EU_UPD: state_next = S_EU_CHK;
            S_CG_DIV:
            begin
                if (div_done)
                begin
                    state_next = (div_rem != '0) ? S_FIN : S_AP_DIV;
                end
            end
            S_AP_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_BP_DIV;
                end
            end
            S_BP_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_X0;
                end
            end
            S_X0:      state_next = S_Y0;
            S_Y0:      state_next = S_Y0_END;
            S_Y0_END:  state_next = S_K_START;
            S_K_START: state_next = S_K_DIV;
            S_K_DIV:
            begin
                if (div_done)
                begin
                    state_next = (kidx_reg == 2'd3) ? S_CNT : S_K_START;
                end
            end
            S_CNT: state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kidx_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_Y0_END)
            begin
                kidx_reg <= 2'd0;
            end
            else if (state_reg == S_K_DIV && div_done && kidx_reg != 2'd3)
            begin
                kidx_reg <= kidx_reg + 2'd1;
            end
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_reg    <= coef_a;
                    b_reg    <= coef_b;
                    c_reg    <= rhs_c;
                    xl_reg   <= x_low;
                    xh_reg   <= x_high;
                    yl_reg   <= y_low;
                    yh_reg   <= y_high;
                    p_reg    <= mag_in(coef_a);
                    q_reg    <= mag_in(coef_b);
                    xp_reg   <= CW'(1);
                    yp_reg   <= '0;
                    xq_reg   <= '0;
                    yq_reg   <= CW'(1);
                    stat_reg <= ldsc_pkg::ST_OK;
                    cnt_reg  <= '0;
                end
            end
            S_EU_CHK:
            begin
                if (p_reg == '0 && zero_coef)
                begin
                    stat_reg <= ldsc_pkg::ST_ZERO;
                end
            end
            S_EU_DIV:
            begin
                if (div_done)
                begin
                    t_reg <= div_quot[MW-1:0];
                    r_reg <= div_rem;
                end
            end
            S_EU_MY:
            begin
                nx_reg <= xq_reg - CW'(prod64);
            end
            S_EU_UPD:
            begin
                yp_reg <= yq_reg - CW'(prod64);
                yq_reg <= yp_reg;
                xp_reg <= nx_reg;
                xq_reg <= xp_reg;
                q_reg  <= p_reg;
                p_reg  <= r_reg;
            end
            S_CG_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem != '0)
                    begin
                        stat_reg <= ldsc_pkg::ST_NODIV;
                    end
                    m_reg <= c_reg[WIDTH-1] ? -quot_s : quot_s;
                end
            end
            S_AP_DIV:
            begin
                if (div_done)
                begin
                    ap_reg <= a_reg[WIDTH-1] ? -quot_s : quot_s;
                end
            end
            S_BP_DIV:
            begin
                if (div_done)
                begin
                    bp_reg <= b_reg[WIDTH-1] ? -quot_s : quot_s;
                end
            end
            S_Y0:
            begin
                x0_reg <= a_reg[WIDTH-1] ? -prod64 : prod64;
            end
            S_Y0_END:
            begin
                y0_reg <= b_reg[WIDTH-1] ? -prod64 : prod64;
            end
            S_K_DIV:
            begin
                if (div_done)
                begin
                    unique case (kidx_reg)
                        2'd0: kl_reg <= k_val;
                        2'd1: kh_reg <= k_val;
                        2'd2:
                        begin
                            if (k_val > kl_reg)
                            begin
                                kl_reg <= k_val;
                            end
                        end
                        default:
                        begin
                            if (k_val < kh_reg)
                            begin
                                kh_reg <= k_val;
                            end
                        end
                    endcase
                end
            end
            S_CNT:
            begin
                cnt_reg <= (kl_reg <= kh_reg) ?
                           ldsc_pkg::COUNT_W'(k_span + NW'(1)) : '0;
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // Output register, loaded when the previous result has been taken.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && out_free)
        begin
            status_out_reg <= stat_reg;
            gcd_out_reg    <= ldsc_pkg::GCD_W'(q_reg);
            if (stat_reg == ldsc_pkg::ST_OK)
            begin
                px_out_reg    <= x0_reg;
                py_out_reg    <= y0_reg;
                count_out_reg <= cnt_reg;
            end
            else
            begin
                px_out_reg    <= '0;
                py_out_reg    <= '0;
                count_out_reg <= '0;
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_out_reg;
    assign gcd_value = gcd_out_reg;
    assign part_x    = px_out_reg;
    assign part_y    = py_out_reg;
    assign box_count = count_out_reg;

endmodule
